>>> rtl/alarm_table_with_snooze_macros.svh
`ifndef ALARM_TABLE_WITH_SNOOZE_MACROS_SVH
`define ALARM_TABLE_WITH_SNOOZE_MACROS_SVH

// Both macros expect signals named clk and rst_n in the module that uses them.

// The consequent must hold in the same cycle as the antecedent.
`define ATS_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm table check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm table check failed");

`endif

>>> rtl/ats_pkg.sv
package ats_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int CHOICE_W = 2;
  localparam int STAT_W   = 4;
  localparam int CNT_W    = 4;
  localparam int LIMIT_W  = 4;
  localparam int TIME_W   = HOUR_W + MIN_W + SEC_W;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 4'd3;
  localparam logic [MIN_W-1:0]   MINUTES_RST = 6'd5;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 4'd15;

  localparam logic [MIN_W:0]   MIN_PER_HOUR   = 7'd60;
  localparam logic [MIN_W:0]   MIN_TWO_HOURS  = 7'd120;
  localparam logic [HOUR_W:0]  HOURS_PER_DAY  = 6'd24;

  typedef enum logic [KIND_W-1:0] {
    K_SET  = 2'd0,
    K_DEL  = 2'd1,
    K_TICK = 2'd2
  } kind_t;

  typedef enum logic [CHOICE_W-1:0] {
    C_NONE   = 2'd0,
    C_SNOOZE = 2'd1,
    C_STOP   = 2'd2
  } choice_t;

  typedef enum logic [STAT_W-1:0] {
    ST_SET        = 4'd0,
    ST_EXISTS     = 4'd1,
    ST_FULL       = 4'd2,
    ST_DELETED    = 4'd3,
    ST_NOT_FOUND  = 4'd4,
    ST_NO_RING    = 4'd5,
    ST_SNOOZED    = 4'd6,
    ST_STOPPED    = 4'd7,
    ST_UNANSWERED = 4'd8
  } stat_t;

  typedef enum logic {
    REG_LIMIT   = 1'b0,
    REG_MINUTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic rd_en;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/ats_if.sv
interface ats_in_if;
  logic                          valid;
  logic                          ready;
  logic [ats_pkg::KIND_W-1:0]    kind;
  logic [ats_pkg::HOUR_W-1:0]    hour;
  logic [ats_pkg::MIN_W-1:0]     minute;
  logic [ats_pkg::SEC_W-1:0]     second;
  logic [ats_pkg::CHOICE_W-1:0]  choice;

  modport source (output valid, kind, hour, minute, second, choice, input ready);
  modport sink   (input valid, kind, hour, minute, second, choice, output ready);
endinterface

interface ats_out_if;
  logic                        valid;
  logic                        ready;
  logic [ats_pkg::STAT_W-1:0]  status;
  logic                        ringing;
  logic [ats_pkg::HOUR_W-1:0]  new_hour;
  logic [ats_pkg::MIN_W-1:0]   new_minute;
  logic [ats_pkg::CNT_W-1:0]   snooze_count;

  modport source (output valid, status, ringing, new_hour, new_minute, snooze_count,
                  input ready);
  modport sink   (input valid, status, ringing, new_hour, new_minute, snooze_count,
                  output ready);
endinterface

>>> rtl/ats_ctrl.sv
`include "alarm_table_with_snooze_macros.svh"

module ats_ctrl #(
  parameter int ALARM_SLOTS = ats_pkg::SLOTS_DEF,
  parameter int AW          = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ats_pkg::sts_t   sts,
  output ats_pkg::cmd_t   cmd,
  output logic [AW-1:0]   rd_addr
);
  import ats_pkg::*;

  localparam logic [AW-1:0] LAST_SLOT = AW'(ALARM_SLOTS - 1);

  ctrl_state_t   state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      // The last slot read is still being compared in this cycle.
      S_DRAIN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = idx_r;

  `ATS_NEXT(a_accept_prep, in_valid && in_ready, state_r == S_PREP)
  `ATS_NEXT(a_scan_from_zero, state_r == S_PREP, state_r == S_SCAN && idx_r == '0)
  `ATS_NEXT(a_exec_to_idle, cmd.exec, state_r == S_IDLE)

endmodule

>>> rtl/ats_dpath.sv
`include "alarm_table_with_snooze_macros.svh"

module ats_dpath #(
  parameter int ALARM_SLOTS = ats_pkg::SLOTS_DEF,
  parameter int AW          = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ats_pkg::cmd_t                 cmd,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [ats_pkg::LIMIT_W-1:0]   snooze_limit,
  input  logic [ats_pkg::MIN_W-1:0]     snooze_minutes,
  ats_in_if.sink                        in_ch,
  ats_out_if.source                     out_ch,
  output ats_pkg::sts_t                 sts
);
  import ats_pkg::*;

  localparam int WW = TIME_W + CNT_W;

  // Captured input beat.
  logic [KIND_W-1:0]   kind_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MIN_W-1:0]    min_r;
  logic [SEC_W-1:0]    sec_r;
  logic [CHOICE_W-1:0] choice_r;

  // Time the alarm would move to on a snooze.
  logic [HOUR_W-1:0]   nh_r;
  logic [MIN_W-1:0]    nm_r;
  logic [MIN_W:0]      msum;
  logic [MIN_W-1:0]    nm_calc;
  logic [1:0]          hcarry;
  logic [HOUR_W:0]     hsum;
  logic [HOUR_W-1:0]   nh_calc;

  // Slot storage: time and snooze count per slot, valid bits in flip-flops.
  logic [WW-1:0]          mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] valid_r;

  // Read stage.
  logic                cmp_en_r;
  logic [AW-1:0]       cmp_idx_r;
  logic [WW-1:0]       rd_data_r;
  logic                rd_vld_r;

  // Scan results.
  logic                   found_r;
  logic [AW-1:0]          slot_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   free_found_r;
  logic [AW-1:0]          free_slot_r;
  logic [ALARM_SLOTS-1:0] dup_r;

  // Output register.
  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r;
  logic                ringing_r;
  logic [HOUR_W-1:0]   new_hour_r;
  logic [MIN_W-1:0]    new_minute_r;
  logic [CNT_W-1:0]    count_r;

  // Execute decision.
  logic [TIME_W-1:0]      cur_t;
  logic [TIME_W-1:0]      mov_t;
  logic [CNT_W-1:0]       cnt_inc;
  logic [ALARM_SLOTS-1:0] slot_oh;
  logic [ALARM_SLOTS-1:0] free_oh;
  logic [ALARM_SLOTS-1:0] vset;
  logic [ALARM_SLOTS-1:0] vclr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [WW-1:0]          wr_data;
  stat_t                  st;
  logic                   ring;
  logic [HOUR_W-1:0]      oh;
  logic [MIN_W-1:0]       om;
  logic [CNT_W-1:0]       oc;
  logic                   rd_hit;
  logic                   rd_dup;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_ch.kind;
      hour_r   <= in_ch.hour;
      min_r    <= in_ch.minute;
      sec_r    <= in_ch.second;
      choice_r <= in_ch.choice;
    end
  end

  // The minute sum stays below three hours, so the carry is found by two compares.
  always_comb begin
    msum = {1'b0, min_r} + {1'b0, snooze_minutes};
    if (msum >= MIN_TWO_HOURS) begin
      nm_calc = MIN_W'(msum - MIN_TWO_HOURS);
      hcarry  = 2'd2;
    end else if (msum >= MIN_PER_HOUR) begin
      nm_calc = MIN_W'(msum - MIN_PER_HOUR);
      hcarry  = 2'd1;
    end else begin
      nm_calc = msum[MIN_W-1:0];
      hcarry  = 2'd0;
    end
    hsum = {1'b0, hour_r} + {{(HOUR_W - 1){1'b0}}, hcarry};
    if (hsum >= HOURS_PER_DAY) begin
      nh_calc = HOUR_W'(hsum - HOURS_PER_DAY);
    end else begin
      nh_calc = hsum[HOUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      nh_r <= nh_calc;
      nm_r <= nm_calc;
    end
  end

  assign cur_t = {hour_r, min_r, sec_r};
  assign mov_t = {nh_r, nm_r, sec_r};

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en && cmd.exec) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= valid_r[rd_addr];
    cmp_idx_r <= rd_addr;
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_en;
    end
  end

  assign rd_hit = rd_vld_r && (rd_data_r[WW-1:CNT_W] == cur_t);
  assign rd_dup = rd_vld_r && (rd_data_r[WW-1:CNT_W] == mov_t);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.prep) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmp_en_r) begin
      if (rd_hit && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= cmp_idx_r;
        cnt_r   <= rd_data_r[CNT_W-1:0];
      end
      if (!rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en_r) begin
      dup_r[cmp_idx_r] <= rd_dup;
    end
  end

  always_comb begin
    cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    slot_oh = ALARM_SLOTS'(1) << slot_r;
    free_oh = ALARM_SLOTS'(1) << free_slot_r;
    st      = ST_NO_RING;
    ring    = 1'b0;
    oh      = '0;
    om      = '0;
    oc      = '0;
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = {mov_t, cnt_inc};
    vset    = '0;
    vclr    = '0;
    unique case (kind_t'(kind_r))
      K_SET: begin
        if (found_r) begin
          st = ST_EXISTS;
        end else if (free_found_r) begin
          st      = ST_SET;
          wr_en   = 1'b1;
          wr_addr = free_slot_r;
          wr_data = {cur_t, {CNT_W{1'b0}}};
          vset    = free_oh;
        end else begin
          st = ST_FULL;
        end
      end
      K_DEL: begin
        if (found_r) begin
          st   = ST_DELETED;
          vclr = slot_oh;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      K_TICK: begin
        if (found_r) begin
          ring = 1'b1;
          oc   = cnt_r;
          unique case (choice_t'(choice_r))
            C_SNOOZE: begin
              oc = cnt_inc;
              if (cnt_inc >= snooze_limit) begin
                st   = ST_STOPPED;
                vclr = slot_oh;
              end else begin
                // The moved alarm replaces any other alarm already at its new time.
                st    = ST_SNOOZED;
                vclr  = dup_r & ~slot_oh;
                wr_en = 1'b1;
                oh    = nh_r;
                om    = nm_r;
              end
            end
            C_STOP: begin
              st   = ST_STOPPED;
              vclr = slot_oh;
            end
            default: begin
              st = ST_UNANSWERED;
            end
          endcase
        end
      end
      default: begin
        st = ST_NO_RING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec) begin
      valid_r <= (valid_r & ~vclr) | vset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.exec) begin
      status_r     <= st;
      ringing_r    <= ring;
      new_hour_r   <= oh;
      new_minute_r <= om;
      count_r      <= oc;
    end
  end

  assign sts.out_busy        = out_valid_r && !out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.ringing      = ringing_r;
  assign out_ch.new_hour     = new_hour_r;
  assign out_ch.new_minute   = new_minute_r;
  assign out_ch.snooze_count = count_r;

  `ATS_IMPLIES(a_exec_reg_free, cmd.exec, !(out_valid_r && !out_ch.ready))
  `ATS_NEXT(a_exec_beat, cmd.exec, out_valid_r)
  `ATS_NEXT(a_valid_hold, rst_n && !cmd.exec, $stable(valid_r))

endmodule

>>> rtl/alarm_table_with_snooze.sv
// Alarm table with snooze. Each input beat (set, delete, clock tick or an unused kind)
// gives exactly one result beat. Each beat passes through these steps in order: the
// accepting cycle captures the beat, a prep step works out the snoozed time, a scan
// walks the slot memory slot by slot through its single read port, a drain step
// finishes the last compare and an execute step updates the table and loads the output
// register. A new beat is taken only once the last one has left its execute step. The
// next beat is accepted while a result still waits in the output register; that item
// then holds in its final step until the register is free. There is no clearing pass
// after reset: slot valid bits reset at once.
// Registers: snooze_limit at byte address 0 (reset 3), snooze_minutes at 4 (reset 5).

module alarm_table_with_snooze #(
  parameter int ALARM_SLOTS = ats_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ats_in_if.sink                      in_ch,
  ats_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ats_pkg::CFG_AW-1:0]  paddr,
  input  logic [ats_pkg::CFG_DW-1:0]  pwdata,
  output logic [ats_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import ats_pkg::*;

  localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  logic [LIMIT_W-1:0] limit_r;
  logic [MIN_W-1:0]   minutes_r;
  cfg_reg_t           reg_sel;
  logic               wr_stb;
  cmd_t               cmd;
  sts_t               sts;
  logic [AW-1:0]      rd_addr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[CFG_AW-1]);
  assign wr_stb  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      minutes_r <= MINUTES_RST;
    end else if (wr_stb) begin
      unique case (reg_sel)
        REG_LIMIT:   limit_r   <= pwdata[LIMIT_W-1:0];
        REG_MINUTES: minutes_r <= pwdata[MIN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LIMIT:   prdata = {{(CFG_DW - LIMIT_W){1'b0}}, limit_r};
      REG_MINUTES: prdata = {{(CFG_DW - MIN_W){1'b0}}, minutes_r};
      default:     prdata = '0;
    endcase
  end

  ats_ctrl #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .AW          (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  ats_dpath #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .AW          (AW)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .snooze_limit   (limit_r),
    .snooze_minutes (minutes_r),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .sts            (sts)
  );

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ats_pkg::*;

  localparam int ALARM_SLOTS = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 222;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 600;
  localparam int N_DIRECTED  = 21;
  localparam int N_SETTINGS  = 6;

  // Encodings the package leaves unnamed: the block must treat them as harmless.
  localparam logic [KIND_W-1:0]   KIND_IGNORED  = 2'd3;
  localparam logic [CHOICE_W-1:0] CHOICE_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SEC_W-1:0]    second;
    logic [CHOICE_W-1:0] choice;
  } alarm_req_t;

  typedef struct packed {
    stat_t             status;
    logic              ringing;
    logic [HOUR_W-1:0] new_hour;
    logic [MIN_W-1:0]  new_minute;
    logic [CNT_W-1:0]  snooze_count;
  } alarm_res_t;

  typedef struct packed {
    alarm_req_t req;
    logic       typed;
    alarm_res_t want;
  } dir_row_t;

  localparam alarm_res_t NO_RING_RES = '{ST_NO_RING, 1'b0, 5'd0, 6'd0, 4'd0};

  // Directed sequence, run with the reset settings (limit 3, five minutes).
  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{'{K_TICK, 5'd0, 6'd0, 6'd0, C_NONE}, 1'b1, NO_RING_RES},
    '{'{K_DEL, 5'd23, 6'd59, 6'd59, C_NONE}, 1'b1, '{ST_NOT_FOUND, 1'b0, 5'd0, 6'd0, 4'd0}},
    '{'{K_SET, 5'd23, 6'd59, 6'd59, C_NONE}, 1'b1, '{ST_SET, 1'b0, 5'd0, 6'd0, 4'd0}},
    '{'{K_SET, 5'd23, 6'd59, 6'd59, C_STOP}, 1'b1, '{ST_EXISTS, 1'b0, 5'd0, 6'd0, 4'd0}},
    '{'{K_TICK, 5'd23, 6'd59, 6'd59, C_SNOOZE}, 1'b1, '{ST_SNOOZED, 1'b1, 5'd0, 6'd4, 4'd1}},
    '{'{K_TICK, 5'd0, 6'd4, 6'd59, C_NONE}, 1'b1, '{ST_UNANSWERED, 1'b1, 5'd0, 6'd0, 4'd1}},
    '{'{K_TICK, 5'd0, 6'd4, 6'd59, CHOICE_UNUSED}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd0, 6'd4, 6'd59, C_SNOOZE}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd0, 6'd9, 6'd59, C_SNOOZE}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd0, 6'd9, 6'd59, C_SNOOZE}, 1'b0, NO_RING_RES},
    '{'{K_SET, 5'd31, 6'd63, 6'd63, C_NONE}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd31, 6'd63, 6'd63, C_SNOOZE}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd8, 6'd8, 6'd63, C_STOP}, 1'b0, NO_RING_RES},
    '{'{KIND_IGNORED, 5'd31, 6'd63, 6'd63, CHOICE_UNUSED}, 1'b1, NO_RING_RES},
    '{'{K_SET, 5'd0, 6'd0, 6'd0, C_NONE}, 1'b0, NO_RING_RES},
    '{'{K_SET, 5'd0, 6'd5, 6'd0, C_NONE}, 1'b0, NO_RING_RES},
    '{'{K_TICK, 5'd0, 6'd0, 6'd0, C_SNOOZE}, 1'b0, NO_RING_RES},
    '{'{K_DEL, 5'd0, 6'd5, 6'd0, C_NONE}, 1'b0, NO_RING_RES},
    '{'{K_DEL, 5'd0, 6'd5, 6'd0, C_NONE}, 1'b1, '{ST_NOT_FOUND, 1'b0, 5'd0, 6'd0, 4'd0}},
    '{'{K_TICK, 5'd12, 6'd30, 6'd0, C_STOP}, 1'b1, NO_RING_RES},
    '{'{K_DEL, 5'd0, 6'd0, 6'd0, C_NONE}, 1'b0, NO_RING_RES}
  };

  localparam logic [LIMIT_W-1:0] LIMIT_SETTING   [0:N_SETTINGS-1] = '{4'd15, 4'd1, 4'd9,
                                                                      4'd0, 4'd6, 4'd5};
  localparam logic [MIN_W-1:0]   MINUTES_SETTING [0:N_SETTINGS-1] = '{6'd59, 6'd1, 6'd0,
                                                                      6'd17, 6'd63, 6'd45};

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  ats_in_if  in_ch ();
  ats_out_if out_ch ();

  alarm_table_with_snooze #(.ALARM_SLOTS(ALARM_SLOTS)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the alarm table and its settings.
  logic                slot_used    [0:ALARM_SLOTS-1];
  logic [TIME_W-1:0]   slot_time    [0:ALARM_SLOTS-1];
  logic [CNT_W-1:0]    slot_snoozes [0:ALARM_SLOTS-1];
  logic [LIMIT_W-1:0]  limit_cfg;
  logic [MIN_W-1:0]    minutes_cfg;

  alarm_res_t        awaited_outcomes [$];
  logic [TIME_W-1:0] time_pool [0:POOL_SIZE-1];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int set_weight;
  int cycle_count;
  int errors;
  int requests_sent;
  int ignored_sent;
  int results_checked;
  int rings_seen;
  int status_seen [0:15];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
             awaited_outcomes.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Time an alarm moves to on a snooze: the minute sum carries into the hour,
  // the hour wraps around the day, and the second is kept.
  function automatic logic [TIME_W-1:0] snooze_target(input logic [TIME_W-1:0] t);
    int msum;
    int nh;
    int nm;
    msum = int'(t[SEC_W +: MIN_W]) + int'(minutes_cfg);
    nm = msum % int'(MIN_PER_HOUR);
    nh = (int'(t[TIME_W-1 -: HOUR_W]) + msum / int'(MIN_PER_HOUR)) % int'(HOURS_PER_DAY);
    return {HOUR_W'(nh), MIN_W'(nm), t[SEC_W-1:0]};
  endfunction

  function automatic alarm_res_t step_alarm_table(input alarm_req_t r);
    alarm_res_t res;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] nt;
    int hit;
    int i;
    res = NO_RING_RES;
    t = {r.hour, r.minute, r.second};
    hit = -1;
    for (i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_time[i] == t) hit = i;
    end
    if (r.kind == K_SET) begin
      if (hit >= 0) begin
        res.status = ST_EXISTS;
      end else begin
        res.status = ST_FULL;
        for (i = 0; i < ALARM_SLOTS && res.status == ST_FULL; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_time[i] = t;
            slot_snoozes[i] = '0;
            res.status = ST_SET;
          end
        end
      end
    end else if (r.kind == K_DEL) begin
      if (hit >= 0) begin
        slot_used[hit] = 1'b0;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (r.kind == K_TICK && hit >= 0) begin
      res.ringing = 1'b1;
      res.snooze_count = slot_snoozes[hit];
      if (r.choice == C_SNOOZE) begin
        if (res.snooze_count != CNT_MAX) res.snooze_count++;
        if (res.snooze_count >= limit_cfg) begin
          slot_used[hit] = 1'b0;
          res.status = ST_STOPPED;
        end else begin
          nt = snooze_target(t);
          // Any other alarm already at the new time is overwritten.
          for (i = 0; i < ALARM_SLOTS; i++) begin
            if (i != hit && slot_used[i] && slot_time[i] == nt) slot_used[i] = 1'b0;
          end
          slot_time[hit] = nt;
          slot_snoozes[hit] = res.snooze_count;
          res.new_hour = nt[TIME_W-1 -: HOUR_W];
          res.new_minute = nt[SEC_W +: MIN_W];
          res.status = ST_SNOOZED;
        end
      end else if (r.choice == C_STOP) begin
        slot_used[hit] = 1'b0;
        res.status = ST_STOPPED;
      end else begin
        res.status = ST_UNANSWERED;
      end
    end
    return res;
  endfunction

  function automatic bit pick_stored(output logic [TIME_W-1:0] t);
    int base;
    int k;
    int i;
    base = $urandom_range(ALARM_SLOTS - 1);
    t = '0;
    for (k = 0; k < ALARM_SLOTS; k++) begin
      i = (base + k) % ALARM_SLOTS;
      if (slot_used[i]) begin
        t = slot_time[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alarm_req_t random_request();
    alarm_req_t r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] s;
    int pick;
    if ($urandom_range(99) < 8) begin
      r.kind = KIND_W'($urandom_range(3));
      r.hour = HOUR_W'($urandom_range(31));
      r.minute = MIN_W'($urandom_range(63));
      r.second = SEC_W'($urandom_range(63));
      r.choice = CHOICE_W'($urandom_range(3));
      return r;
    end
    pick = $urandom_range(99);
    if (pick < set_weight) r.kind = K_SET;
    else if (pick < set_weight + 15) r.kind = K_DEL;
    else if (pick < 96) r.kind = K_TICK;
    else r.kind = KIND_IGNORED;
    t = time_pool[$urandom_range(POOL_SIZE - 1)];
    // Mostly aim at stored alarms so that ticks ring and deletes hit.
    if (r.kind != K_SET && $urandom_range(99) < 65 && pick_stored(s)) t = s;
    // Some sets land where a stored alarm would snooze to, to provoke overwrites.
    if (r.kind == K_SET && $urandom_range(99) < 20 && pick_stored(s)) t = snooze_target(s);
    {r.hour, r.minute, r.second} = t;
    pick = $urandom_range(99);
    if (pick < 45) r.choice = C_SNOOZE;
    else if (pick < 70) r.choice = C_STOP;
    else if (pick < 92) r.choice = C_NONE;
    else r.choice = CHOICE_UNUSED;
    return r;
  endfunction

  task automatic refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(9) == 0) begin
        time_pool[i] = {5'($urandom_range(31)), 6'($urandom_range(63)), 6'($urandom_range(63))};
      end else begin
        time_pool[i] = {5'($urandom_range(23)), 6'($urandom_range(59)), 6'($urandom_range(59))};
      end
    end
  endtask

  task automatic offer_request(input alarm_req_t r, input logic typed, input alarm_res_t want);
    alarm_res_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= r.kind;
    in_ch.hour   <= r.hour;
    in_ch.minute <= r.minute;
    in_ch.second <= r.second;
    in_ch.choice <= r.choice;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = step_alarm_table(r);
    awaited_outcomes.push_back(typed ? want : pred);
    requests_sent++;
    if (r.kind == KIND_IGNORED) ignored_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_LIMIT) limit_cfg = value[LIMIT_W-1:0];
    else minutes_cfg = value[MIN_W-1:0];
  endtask

  task automatic check_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      flag_error($sformatf("register %s read back %0d, expected %0d", idx.name(), got, want));
    end
  endtask

  task automatic load_snooze_settings(input logic [LIMIT_W-1:0] lim,
                                      input logic [MIN_W-1:0] mins);
    write_reg(REG_LIMIT, CFG_DW'(lim));
    write_reg(REG_MINUTES, CFG_DW'(mins));
    check_reg(REG_LIMIT, CFG_DW'(lim));
    check_reg(REG_MINUTES, CFG_DW'(mins));
  endtask

  // Result side: ready toggles at random, except during a deliberate hold-off.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    alarm_res_t got;
    alarm_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status       = stat_t'(out_ch.status);
      got.ringing      = out_ch.ringing;
      got.new_hour     = out_ch.new_hour;
      got.new_minute   = out_ch.new_minute;
      got.snooze_count = out_ch.snooze_count;
      results_checked++;
      status_seen[out_ch.status]++;
      if (out_ch.ringing) rings_seen++;
      if (awaited_outcomes.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with nothing outstanding",
                             results_checked));
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.status !== want.status || got.ringing !== want.ringing ||
            got.new_hour !== want.new_hour || got.new_minute !== want.new_minute ||
            got.snooze_count !== want.snooze_count) begin
          flag_error($sformatf({"result %0d: expected status %0d ring %0d time %0d:%0d ",
                                "count %0d, got status %0d ring %0d time %0d:%0d count %0d"},
                               results_checked, want.status, want.ringing, want.new_hour,
                               want.new_minute, want.snooze_count, out_ch.status,
                               got.ringing, got.new_hour, got.new_minute,
                               got.snooze_count));
        end
      end
    end
  end

  initial begin
    alarm_req_t r;
    int i;
    int ph;
    int counted;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.hour = '0;
    in_ch.minute = '0;
    in_ch.second = '0;
    in_ch.choice = '0;
    out_ch.ready = 1'b0;
    rx_hold_left = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 57;
    set_weight = 40;
    errors = 0;
    requests_sent = 0;
    ignored_sent = 0;
    results_checked = 0;
    rings_seen = 0;
    for (i = 0; i < 16; i++) status_seen[i] = 0;
    for (i = 0; i < ALARM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_time[i] = '0;
      slot_snoozes[i] = '0;
    end
    limit_cfg = LIMIT_RST;
    minutes_cfg = MINUTES_RST;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_reg(REG_LIMIT, CFG_DW'(LIMIT_RST));
    check_reg(REG_MINUTES, CFG_DW'(MINUTES_RST));

    for (i = 0; i < N_DIRECTED; i++) begin
      offer_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (ph = 0; ph < N_SETTINGS; ph++) begin
      drain_results();
      load_snooze_settings(LIMIT_SETTING[ph], MINUTES_SETTING[ph]);
      case (ph / 2)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // With nobody idling, stall the result side for a long stretch so the
      // block backs up and holds off its input.
      if (ph == 4) rx_hold_left = HOLD_CYCLES;
      set_weight = (ph % 2 == 0) ? 50 : 30;
      refresh_pool();
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        offer_request(r, 1'b0, NO_RING_RES);
        if (r.kind != KIND_IGNORED) counted++;
      end
    end

    drain_results();
    repeat (ALARM_SLOTS + 8) @(posedge clk);

    $display("run covered %0d requests, %0d of the unused kind, over %0d snooze settings",
             requests_sent, ignored_sent, N_SETTINGS + 1);
    $display("%0d results: %0d rings, %0d snoozes, %0d removals, %0d full, %0d duplicates",
             results_checked, rings_seen, status_seen[ST_SNOOZED], status_seen[ST_STOPPED],
             status_seen[ST_FULL], status_seen[ST_EXISTS]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
